// File: rtl/nsq_pkg.sv
// Shared types and constants for the stack/queue manager.
// Depends on nothing; used by every rtl module of the block.
`timescale 1ns / 1ps

package nsq_pkg;

  localparam int NumLists  = 16;
  localparam int ListDepth = 64;
  localparam int ValueW    = 32;

  localparam int IdW   = 4;                        // width of the list_id field
  localparam int LidW  = $clog2(NumLists);          // bits that index a list
  localparam int PtrW  = $clog2(ListDepth);
  localparam int CntW  = $clog2(ListDepth + 1);
  localparam int AddrW = LidW + PtrW;

  // entry store: one ring of ListDepth entries per list
  localparam int StoreDepth = NumLists * ListDepth;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CmdCreate = 2'd0,
    CmdPush   = 2'd1,
    CmdPop    = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StPopped  = 3'd1,
    StExists  = 3'd2,
    StMissing = 3'd3,
    StEmpty   = 3'd4,
    StFull    = 3'd5
  } status_e;

  localparam logic KindQueue = 1'b0;
  localparam logic KindStack = 1'b1;

  // one classified item on its way to the store
  typedef struct packed {
    status_e            status;
    logic               is_write;
    logic               is_pop;
    logic [AddrW-1:0]   addr;
    logic [ValueW-1:0]  value;
  } op_t;

endpackage

// File: rtl/nsq_front.sv
// Front end: accepts command items, checks them against the per-list
// pointer/count table and emits a classified store operation.
// Depends on nsq_pkg.
`timescale 1ns / 1ps

module nsq_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [1:0]               cmd_i,
  input  logic [nsq_pkg::IdW-1:0]  list_id_i,
  input  logic                     kind_i,
  input  logic [31:0]              push_value_i,
  output nsq_pkg::op_t             op_o
);

  logic [nsq_pkg::NumLists-1:0] valid_q, stack_q;
  logic [nsq_pkg::PtrW-1:0]     rp_q  [nsq_pkg::NumLists];
  logic [nsq_pkg::CntW-1:0]     cnt_q [nsq_pkg::NumLists];

  logic [nsq_pkg::LidW-1:0] idx;
  logic                     in_range;
  logic                     cur_valid, cur_stack;
  logic [nsq_pkg::PtrW-1:0] cur_rp, rp_d, pos;
  logic [nsq_pkg::CntW-1:0] cur_cnt, cnt_d;
  logic                     do_create, do_update;

  assign idx       = list_id_i[nsq_pkg::LidW-1:0];
  assign in_range  = 32'(list_id_i) < nsq_pkg::NumLists;
  assign cur_valid = valid_q[idx];
  assign cur_stack = stack_q[idx];
  assign cur_rp    = rp_q[idx];
  assign cur_cnt   = cnt_q[idx];

  always_comb begin
    do_create   = 1'b0;
    do_update   = 1'b0;
    rp_d        = cur_rp;
    cnt_d       = cur_cnt;
    pos         = cur_rp;
    op_o.status = nsq_pkg::StOk;
    op_o.is_write = 1'b0;
    op_o.is_pop   = 1'b0;
    op_o.value    = push_value_i[nsq_pkg::ValueW-1:0];
    case (nsq_pkg::cmd_e'(cmd_i))
      nsq_pkg::CmdCreate: begin
        if (!in_range) begin
          op_o.status = nsq_pkg::StMissing;
        end else if (cur_valid) begin
          op_o.status = nsq_pkg::StExists;
        end else begin
          do_create = 1'b1;
        end
      end
      nsq_pkg::CmdPush: begin
        if (!in_range || !cur_valid) begin
          op_o.status = nsq_pkg::StMissing;
        end else if (cur_cnt == nsq_pkg::CntW'(nsq_pkg::ListDepth)) begin
          op_o.status = nsq_pkg::StFull;
        end else begin
          // stack grows downward from the read pointer, queue appends behind it
          if (cur_stack == nsq_pkg::KindStack) begin
            rp_d = cur_rp - nsq_pkg::PtrW'(1);
            pos  = rp_d;
          end else begin
            pos  = cur_rp + cur_cnt[nsq_pkg::PtrW-1:0];
          end
          cnt_d         = cur_cnt + nsq_pkg::CntW'(1);
          do_update     = 1'b1;
          op_o.is_write = 1'b1;
        end
      end
      nsq_pkg::CmdPop: begin
        if (!in_range || !cur_valid) begin
          op_o.status = nsq_pkg::StMissing;
        end else if (cur_cnt == '0) begin
          op_o.status = nsq_pkg::StEmpty;
        end else begin
          rp_d        = cur_rp + nsq_pkg::PtrW'(1);
          cnt_d       = cur_cnt - nsq_pkg::CntW'(1);
          do_update   = 1'b1;
          op_o.is_pop = 1'b1;
          op_o.status = nsq_pkg::StPopped;
        end
      end
      default: begin
        op_o.status = nsq_pkg::StOk;
      end
    endcase
    op_o.addr = {idx, pos};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      stack_q <= '0;
      for (int i = 0; i < nsq_pkg::NumLists; i++) begin
        rp_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (do_create) begin
        valid_q[idx] <= 1'b1;
        stack_q[idx] <= kind_i;
        rp_q[idx]    <= '0;
        cnt_q[idx]   <= '0;
      end else if (do_update) begin
        rp_q[idx]    <= rp_d;
        cnt_q[idx]   <= cnt_d;
      end
    end
  end

endmodule

// File: rtl/nsq_queue.sv
// Short in-order queue of classified operations between front and back.
// Depends on nsq_pkg.
`timescale 1ns / 1ps

module nsq_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nsq_pkg::op_t  op_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output nsq_pkg::op_t  op_o
);

  nsq_pkg::op_t               slot_q [nsq_pkg::QDepth];
  logic [nsq_pkg::QPtrW-1:0]  wr_q, rd_q;
  logic [nsq_pkg::QCntW-1:0]  cnt_q;
  logic                       do_pop;

  assign full_o  = cnt_q == nsq_pkg::QCntW'(nsq_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign op_o    = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + nsq_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + nsq_pkg::QPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + nsq_pkg::QCntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - nsq_pkg::QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/nsq_back.sv
// Back end: owns the entry store, performs one write or read per item and
// presents the result for one cycle.  Depends on nsq_pkg.
`timescale 1ns / 1ps

module nsq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  nsq_pkg::op_t  op_i,
  output logic          result_valid_o,
  output logic [2:0]    status_o,
  output logic [31:0]   pop_value_o
);

  logic [nsq_pkg::ValueW-1:0] store_q [nsq_pkg::StoreDepth];
  logic [nsq_pkg::ValueW-1:0] rdata_q;
  nsq_pkg::status_e           status_q;
  logic                       is_pop_q;
  logic                       vld_q;

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_i.is_write) begin
      store_q[op_i.addr] <= op_i.value;
    end
    rdata_q  <= store_q[op_i.addr];
    status_q <= op_i.status;
    is_pop_q <= op_i.is_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= op_valid_i;
    end
  end

  assign result_valid_o = vld_q;
  assign status_o       = status_q;
  assign pop_value_o    = is_pop_q ? 32'(signed'(rdata_q)) : '0;

endmodule

// File: rtl/named_stack_queue_manager_top.sv
// Top level of the stack/queue manager: front, queue and back end.
// Depends on nsq_pkg, nsq_front, nsq_queue, nsq_back.
`timescale 1ns / 1ps

// A bank of 16 lists of signed 32-bit values, each created once as a FIFO
// queue or a LIFO stack and holding up to 64 entries. An item is taken at a
// clock edge where start is high and busy is low; each item gives exactly one
// result, shown on status_o/pop_value_o for a single cycle with
// result_valid_o high. The receiver cannot stall. Results come back in
// item order. The list table update and the queue write take place at
// the accepting edge; the back end then pops the queued item and does
// the registered entry-store access, which yields the result. The front
// end updates the list table while accepting, so a new item can be taken
// in every cycle; the back end does one entry-store access per cycle and
// drains the queue at that rate, so the queue never holds more than one
// item and busy never rises. The entry store is a 1024 x 32 RAM with no
// reset.

module named_stack_queue_manager_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  list_id_i,
  input  logic        kind_i,
  input  logic [31:0] push_value_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] pop_value_o
);

  logic         accept;
  logic         q_full, q_valid;
  nsq_pkg::op_t front_op, back_op;

  // accept when the queue has room
  assign busy   = q_full;
  assign accept = start && !q_full;

  nsq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .list_id_i    (list_id_i),
    .kind_i       (kind_i),
    .push_value_i (push_value_i),
    .op_o         (front_op)
  );

  // back end never stalls, so it pops whenever something is queued
  nsq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .op_i    (front_op),
    .pop_i   (1'b1),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (back_op)
  );

  nsq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (q_valid),
    .op_i           (back_op),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .pop_value_o    (pop_value_o)
  );

endmodule

// File: rtl/nsq_checker.sv
// Port-level checker for the stack/queue manager, bound to the top level.
// Depends on nsq_pkg and named_stack_queue_manager_top.
`timescale 1ns / 1ps

module nsq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd_i,
  input logic        result_valid_o,
  input logic [2:0]  status_o,
  input logic [31:0] pop_value_o
);

  // every accepted item shows its result once it has passed the queue and back-end registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // value is zero unless the item popped
  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != 3'(nsq_pkg::StPopped)) |-> pop_value_o == '0)
    else $error("nonzero pop value on non-pop result");

  // unused command code always answers ok
  a_unused_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == 2'(nsq_pkg::CmdNone))
      |=> ##1 (status_o == 3'(nsq_pkg::StOk)))
    else $error("unused command did not return ok");

endmodule

bind named_stack_queue_manager_top nsq_checker u_nsq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .pop_value_o    (pop_value_o)
);

// File: verif/testbench.sv
// Self-checking testbench for named_stack_queue_manager_top: directed and random commands
// checked against a cycle-free list bank tracker. Depends on rtl/nsq_pkg.sv and the RTL.
`timescale 1ns / 1ps

module testbench;

  // Tracks the list bank and holds the results still to come, oldest first.
  class list_bank_tracker;
    typedef struct {
      nsq_pkg::status_e           status;
      logic [nsq_pkg::ValueW-1:0] value;
    } list_result_t;

    bit                         is_live [nsq_pkg::NumLists];
    bit                         is_stack[nsq_pkg::NumLists];
    logic [nsq_pkg::PtrW-1:0]   head    [nsq_pkg::NumLists];
    logic [nsq_pkg::CntW-1:0]   fill    [nsq_pkg::NumLists];
    logic [nsq_pkg::ValueW-1:0] slots   [nsq_pkg::NumLists*nsq_pkg::ListDepth];
    list_result_t               due_results[$];
    int                         error_count;
    int                         cmd_seen[4];
    int                         status_seen[6];

    function new();
      foreach (head[i]) begin
        head[i] = '0;
        fill[i] = '0;
      end
    endfunction

    function void note_command(nsq_pkg::cmd_e cmd, logic [nsq_pkg::IdW-1:0] id, logic kind,
                               logic [nsq_pkg::ValueW-1:0] value);
      list_result_t r;
      int slot;
      r.status = nsq_pkg::StOk;
      r.value = '0;
      cmd_seen[cmd]++;
      case (cmd)
        nsq_pkg::CmdCreate: begin
          if (is_live[id]) begin
            r.status = nsq_pkg::StExists;
          end else begin
            is_live[id] = 1'b1;
            is_stack[id] = kind;
            head[id] = '0;
            fill[id] = '0;
          end
        end
        nsq_pkg::CmdPush: begin
          if (!is_live[id]) begin
            r.status = nsq_pkg::StMissing;
          end else if (fill[id] == nsq_pkg::CntW'(nsq_pkg::ListDepth)) begin
            r.status = nsq_pkg::StFull;
          end else begin
            if (is_stack[id]) begin
              head[id] = head[id] - nsq_pkg::PtrW'(1);
              slot = int'(id) * nsq_pkg::ListDepth + int'(head[id]);
            end else begin
              slot = int'(id) * nsq_pkg::ListDepth
                   + ((int'(head[id]) + int'(fill[id])) % nsq_pkg::ListDepth);
            end
            slots[slot] = value;
            fill[id] = fill[id] + nsq_pkg::CntW'(1);
          end
        end
        nsq_pkg::CmdPop: begin
          if (!is_live[id]) begin
            r.status = nsq_pkg::StMissing;
          end else if (fill[id] == '0) begin
            r.status = nsq_pkg::StEmpty;
          end else begin
            r.status = nsq_pkg::StPopped;
            r.value = slots[int'(id) * nsq_pkg::ListDepth + int'(head[id])];
            head[id] = head[id] + nsq_pkg::PtrW'(1);
            fill[id] = fill[id] - nsq_pkg::CntW'(1);
          end
        end
        default: ;
      endcase
      status_seen[r.status]++;
      due_results.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [nsq_pkg::ValueW-1:0] value);
      list_result_t e;
      if (due_results.size() == 0) begin
        $error("result with no item pending: status %0d, pop_value %h", status, value);
        error_count++;
        return;
      end
      e = due_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d (%s), got %0d", e.status, e.status.name(), status);
        error_count++;
      end
      if (value !== e.value) begin
        $error("pop_value: expected %h, got %h", e.value, value);
        error_count++;
      end
    endfunction
  endclass

  // Random part is split into segments, each with its own command mix.
  typedef enum int {SegMixed, SegFill, SegDrain, SegNoise} seg_mode_e;

  localparam int RandomItems = 1600;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic [1:0]  cmd_i        = nsq_pkg::CmdNone;
  logic [3:0]  list_id_i    = '0;
  logic        kind_i       = nsq_pkg::KindQueue;
  logic [31:0] push_value_i = '0;
  logic        busy;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [31:0] pop_value_o;

  list_bank_tracker tracker = new();
  int items_sent;

  named_stack_queue_manager_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .list_id_i      (list_id_i),
    .kind_i         (kind_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .pop_value_o    (pop_value_o)
  );

  always #2 clk_i = ~clk_i;

  // Monitor: all sampling happens on the pre-edge values. A result at this
  // edge always belongs to an item taken at an earlier edge, so checking
  // before noting the new item keeps the queue order right.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) tracker.check_result(status_o, pop_value_o);
      if (start && !busy) begin
        tracker.note_command(nsq_pkg::cmd_e'(cmd_i), list_id_i, kind_i, push_value_i);
      end
    end
  end

  // Mostly back-to-back, some short pauses, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until the block takes it. Start stays high
  // when no gap follows, so the next item goes out on the very next edge.
  task automatic send_item(nsq_pkg::cmd_e cmd, logic [3:0] id, logic kind, logic [31:0] value,
                           int idle);
    start        <= 1'b1;
    cmd_i        <= cmd;
    list_id_i    <= id;
    kind_i       <= kind;
    push_value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every outstanding result has come back.
  // The first edge lets the monitor note an item taken on the last edge.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    seg_mode_e      mode;
    nsq_pkg::cmd_e  cmd;
    logic [3:0]     focus;
    logic [3:0]     id;
    int             seg_len;
    int             roll;
    bit             no_idle;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: missing lists, double create, empty pops, value extremes,
    // FIFO vs LIFO order, and the unused command code.
    send_item(nsq_pkg::CmdPop,    4'd3,  nsq_pkg::KindQueue, 32'h0000_0000, 0);
    send_item(nsq_pkg::CmdPush,   4'd3,  nsq_pkg::KindQueue, 32'h1234_5678, 0);
    send_item(nsq_pkg::CmdCreate, 4'd0,  nsq_pkg::KindQueue, 32'h0000_0000, 0);
    send_item(nsq_pkg::CmdCreate, 4'd0,  nsq_pkg::KindStack, 32'hffff_ffff, 0);
    send_item(nsq_pkg::CmdCreate, 4'd15, nsq_pkg::KindStack, 32'h0000_0000, 1);
    send_item(nsq_pkg::CmdPop,    4'd0,  nsq_pkg::KindQueue, 32'h0000_0000, 0);
    send_item(nsq_pkg::CmdPush,   4'd0,  nsq_pkg::KindQueue, 32'h7fff_ffff, 0);
    send_item(nsq_pkg::CmdPush,   4'd0,  nsq_pkg::KindQueue, 32'h8000_0000, 0);
    send_item(nsq_pkg::CmdPush,   4'd0,  nsq_pkg::KindQueue, 32'hffff_ffff, 0);
    send_item(nsq_pkg::CmdPush,   4'd0,  nsq_pkg::KindQueue, 32'h0000_0000, 0);
    repeat (4) send_item(nsq_pkg::CmdPop, 4'd0, nsq_pkg::KindQueue, 32'h0000_0000, 0);
    send_item(nsq_pkg::CmdPush,   4'd15, nsq_pkg::KindStack, 32'h0000_0001, 0);
    send_item(nsq_pkg::CmdPush,   4'd15, nsq_pkg::KindStack, 32'ha5a5_a5a5, 2);
    send_item(nsq_pkg::CmdPush,   4'd15, nsq_pkg::KindStack, 32'h5a5a_5a5a, 0);
    repeat (4) send_item(nsq_pkg::CmdPop, 4'd15, nsq_pkg::KindStack, 32'h0000_0000, 0);
    send_item(nsq_pkg::CmdNone,   4'd7,  nsq_pkg::KindStack, 32'hdead_beef, 0);
    send_item(nsq_pkg::CmdNone,   4'd0,  nsq_pkg::KindQueue, 32'h0000_0000, 0);
    wait_drained();

    // Random: fill segments hammer one list past full, drain segments empty
    // it again (ring pointers wrap), mixed and noise segments spread
    // commands over all lists including unused codes.
    while (items_sent < RandomItems) begin
      roll = $urandom_range(0, 99);
      mode = roll < 35 ? SegMixed : roll < 65 ? SegFill : roll < 90 ? SegDrain : SegNoise;
      focus = 4'($urandom_range(0, 15));
      seg_len = $urandom_range(60, 140);
      no_idle = ($urandom_range(0, 3) == 0);
      if (mode == SegFill || mode == SegDrain) begin
        send_item(nsq_pkg::CmdCreate, focus, 1'($urandom_range(0, 1)), $urandom(), 0);
      end
      for (int k = 0; k < seg_len; k++) begin
        id = focus;
        roll = $urandom_range(0, 99);
        case (mode)
          SegFill: begin
            cmd = roll < 90 ? nsq_pkg::CmdPush : nsq_pkg::CmdPop;
            if (roll >= 97) id = 4'($urandom_range(0, 15));
          end
          SegDrain: cmd = roll < 90 ? nsq_pkg::CmdPop : nsq_pkg::CmdPush;
          SegMixed: begin
            id = 4'($urandom_range(0, 15));
            cmd = roll < 8 ? nsq_pkg::CmdCreate : roll < 52 ? nsq_pkg::CmdPush : nsq_pkg::CmdPop;
          end
          default: begin
            id = 4'($urandom_range(0, 15));
            cmd = nsq_pkg::cmd_e'($urandom_range(0, 3));
          end
        endcase
        send_item(cmd, id, 1'($urandom_range(0, 1)), $urandom(), no_idle ? 0 : pick_gap());
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.due_results.size() != 0) begin
      $error("%0d results never arrived", tracker.due_results.size());
      tracker.error_count++;
    end

    $display("Sent %0d items: %0d create, %0d push, %0d pop, %0d unused code.", items_sent,
             tracker.cmd_seen[nsq_pkg::CmdCreate], tracker.cmd_seen[nsq_pkg::CmdPush],
             tracker.cmd_seen[nsq_pkg::CmdPop], tracker.cmd_seen[nsq_pkg::CmdNone]);
    $display("Outcomes: ok %0d, popped %0d, exists %0d, missing %0d, empty %0d, full %0d.",
             tracker.status_seen[nsq_pkg::StOk], tracker.status_seen[nsq_pkg::StPopped],
             tracker.status_seen[nsq_pkg::StExists], tracker.status_seen[nsq_pkg::StMissing],
             tracker.status_seen[nsq_pkg::StEmpty], tracker.status_seen[nsq_pkg::StFull]);
    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1600 items, each with
  // at most the longest pick_gap pause plus the time for its result).
  initial begin
    #2_000_000;
    $display("Timeout: stimulus or results stalled");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
